// ----- rtl/skrf_pkg.sv -----
// Shared types and constants for the scalar Kalman rate fusion block.
// Used by skrf_div and scalar_kalman_rate_fusion; depends on nothing else.
`default_nettype none

package skrf_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = 64;
  // Quotients of both divisions stay below 2^33.
  localparam int unsigned QUO_W      = 33;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [DATA_W-1:0] VAR_RESET      = 32'd65536000;
  localparam logic [DATA_W-1:0] PROC_VAR_RESET = 32'd262144;
  localparam logic [DATA_W-1:0] SENS_VAR_RESET = 32'd32768;

  // Configuration register indexes.
  localparam logic REG_PROC_VAR = 1'b0;
  localparam logic REG_SENS_VAR = 1'b1;

  // Input item kinds carried on in_tuser.
  localparam logic FUNC_ENCODER = 1'b0;
  localparam logic FUNC_GYRO    = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_nz;
  } div_sts_t;

endpackage : skrf_pkg

`default_nettype wire

// ----- rtl/skrf_div.sv -----
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 33-bit divisor.
// Depends on skrf_pkg; the caller guarantees the quotient fits QUO_W bits.
`default_nettype none

module skrf_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [skrf_pkg::PROD_W-1:0]       dividend,
  input  wire logic [skrf_pkg::QUO_W-1:0]        divisor,
  output logic      [skrf_pkg::QUO_W-1:0]        quotient,
  output skrf_pkg::div_sts_t                     sts
);

  logic [skrf_pkg::QUO_W-1:0]     rem_r;
  // Holds the low dividend bits; quotient bits shift in from the bottom.
  logic [skrf_pkg::QUO_W-1:0]     dvd_r;
  logic [skrf_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           done_r;

  logic [skrf_pkg::QUO_W:0]       trial;
  logic [skrf_pkg::QUO_W+1:0]     diff;
  logic                           qbit;
  logic [skrf_pkg::QUO_W-1:0]     rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[skrf_pkg::QUO_W-1]};
    diff    = {1'b0, trial} - {2'b00, divisor};
    qbit    = ~diff[skrf_pkg::QUO_W+1];
    rem_nxt = qbit ? diff[skrf_pkg::QUO_W-1:0] : trial[skrf_pkg::QUO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= skrf_pkg::DIV_CNT_W'(skrf_pkg::DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == skrf_pkg::DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // The dividend is below divisor * 2^33, so its top bits start below the divisor.
      rem_r <= {2'b00, dividend[skrf_pkg::PROD_W-1:skrf_pkg::QUO_W]};
      dvd_r <= dividend[skrf_pkg::QUO_W-1:0];
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[skrf_pkg::QUO_W-2:0], qbit};
    end
  end

  assign quotient   = dvd_r;
  assign sts.busy   = (cnt_r != '0);
  assign sts.done   = done_r;
  assign sts.rem_nz = |rem_r;

endmodule : skrf_div

`default_nettype wire

// ----- rtl/scalar_kalman_rate_fusion.sv -----
// Channel   Dir  Payload                                          Handshake
// in_       in   tdata: rate_sample[31:0]; tuser: func            in_tvalid / in_tready
// out_      out  tdata: filtered_rate[31:0], estimate_variance    out_tvalid / out_tready
// cfg_      in   cfg_addr: register index, cfg_wdata[31:0]        cfg_we
//
// A gyro item or the first encoder item after reset is handled in S_IDLE alone. Every later
// encoder item makes two passes through the shared 33-step divider, each fed by the shared
// multiplier, before a valid result; a zero denominator skips both passes.
// in_tready is low while an item is in work; a held result stalls only the final step.
// Reset (rst_n low, synchronous) loads the default variances and filter state.
`default_nettype none

module scalar_kalman_rate_fusion (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] rate_sample
  input  wire logic        in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,  // [31:0] filtered_rate, [63:32] estimate_variance
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_PRED, S_PREP, S_MUL1, S_DIV1, S_MUL2, S_DIV2, S_FIN
  } state_t;

  state_t             state_r;
  logic        [31:0] pv_r;
  logic        [31:0] sv_r;
  logic signed [31:0] est_r;
  logic        [31:0] var_r;
  logic signed [31:0] gyro_r;
  logic signed [31:0] last_enc_r;
  logic               first_r;
  logic signed [31:0] rate_r;
  logic        [31:0] p_r;
  logic        [32:0] den_r;
  logic               neg_r;
  logic        [32:0] mag_r;
  logic        [63:0] prod_r;
  logic               start_r;
  logic               rnz_r;
  logic               zden_r;
  logic signed [34:0] s_r;
  logic        [31:0] out_rate_r;
  logic        [31:0] out_var_r;
  logic               out_valid_r;

  logic        [32:0]       quotient;
  skrf_pkg::div_sts_t       div_sts;

  logic signed [33:0] pred_sum;
  logic signed [31:0] pred_sat;
  logic        [32:0] p_sum;
  logic signed [32:0] diff_d;
  logic        [32:0] mul_b;
  logic        [64:0] mul_full;
  logic signed [34:0] s_adj;
  logic signed [31:0] mean_sat;
  logic               out_free;

  skrf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (prod_r),
    .divisor  (den_r),
    .quotient (quotient),
    .sts      (div_sts)
  );

  always_comb begin
    // Prediction: estimate plus change in encoder rate, saturated to 32 bits.
    pred_sum = 34'(est_r) + 34'(rate_r) - 34'(last_enc_r);
    if (pred_sum > 34'sd2147483647) begin
      pred_sat = 32'sh7fffffff;
    end else if (pred_sum < -34'sd2147483648) begin
      pred_sat = 32'sh80000000;
    end else begin
      pred_sat = pred_sum[31:0];
    end

    p_sum  = {1'b0, var_r} + {1'b0, pv_r};
    diff_d = 33'(gyro_r) - 33'(est_r);

    // One multiplier serves both products.
    mul_b    = (state_r == S_MUL1) ? mag_r : {1'b0, sv_r};
    mul_full = {33'd0, p_r} * {32'd0, mul_b};

    // The true quotient truncates toward zero; undo the floor where the sign crossed.
    s_adj = s_r;
    if (rnz_r && neg_r && (s_r > 35'sd0)) begin
      s_adj = s_r - 35'sd1;
    end else if (rnz_r && !neg_r && (s_r < 35'sd0)) begin
      s_adj = s_r + 35'sd1;
    end
    if (s_adj > 35'sd2147483647) begin
      mean_sat = 32'sh7fffffff;
    end else if (s_adj < -35'sd2147483648) begin
      mean_sat = 32'sh80000000;
    end else begin
      mean_sat = s_adj[31:0];
    end

    out_free = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pv_r        <= skrf_pkg::PROC_VAR_RESET;
      sv_r        <= skrf_pkg::SENS_VAR_RESET;
      est_r       <= '0;
      var_r       <= skrf_pkg::VAR_RESET;
      gyro_r      <= '0;
      last_enc_r  <= '0;
      first_r     <= 1'b1;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_addr)
          skrf_pkg::REG_PROC_VAR: pv_r <= cfg_wdata;
          skrf_pkg::REG_SENS_VAR: sv_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            if (in_tuser == skrf_pkg::FUNC_GYRO) begin
              gyro_r <= in_tdata;
            end else if (first_r) begin
              est_r      <= in_tdata;
              last_enc_r <= in_tdata;
              first_r    <= 1'b0;
            end else begin
              rate_r  <= in_tdata;
              state_r <= S_PRED;
            end
          end
        end
        S_PRED: begin
          est_r   <= pred_sat;
          p_r     <= p_sum[32] ? 32'hffffffff : p_sum[31:0];
          state_r <= S_PREP;
        end
        S_PREP: begin
          den_r   <= {1'b0, p_r} + {1'b0, sv_r};
          neg_r   <= diff_d[32];
          mag_r   <= diff_d[32] ? 33'(-diff_d) : 33'(diff_d);
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          prod_r <= mul_full[63:0];
          zden_r <= (den_r == '0);
          if (den_r == '0) begin
            state_r <= S_FIN;
          end else begin
            start_r <= 1'b1;
            state_r <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_sts.done) begin
            rnz_r   <= div_sts.rem_nz;
            state_r <= S_MUL2;
          end
        end
        S_MUL2: begin
          s_r     <= neg_r ? (35'(est_r) - {2'b00, quotient})
                           : (35'(est_r) + {2'b00, quotient});
          prod_r  <= mul_full[63:0];
          start_r <= 1'b1;
          state_r <= S_DIV2;
        end
        S_DIV2: begin
          if (div_sts.done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (zden_r) begin
              var_r      <= '0;
              out_var_r  <= '0;
              out_rate_r <= est_r;
            end else begin
              est_r      <= mean_sat;
              var_r      <= quotient[31:0];
              out_var_r  <= quotient[31:0];
              out_rate_r <= mean_sat;
            end
            last_enc_r  <= rate_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_var_r, out_rate_r};

`ifndef ASSERT_OFF
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_sts.busy)
    else $error("divider busy while taking a new item");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider finished outside a divide state");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised without a final step");
`endif

endmodule : scalar_kalman_rate_fusion

`default_nettype wire
